>>> design/priority_rr_two_queue_scheduler_macros.svh
// Assertion macros for the two-queue scheduler
`ifndef PRIORITY_RR_TWO_QUEUE_SCHEDULER_MACROS_SVH
`define PRIORITY_RR_TWO_QUEUE_SCHEDULER_MACROS_SVH
// assert that prop holds on every clock edge outside reset
`define PRTQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// assert that cause is followed next cycle by effect
`define PRTQ_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);
`endif

>>> design/prtq_pkg.sv
// Shared types and constants for the two-queue scheduler
package prtq_pkg;
	localparam int MaxJobs = 16;
	localparam int IdxW = $clog2(MaxJobs);
	localparam int CntW = $clog2(MaxJobs + 1);
	localparam logic [7:0] QuantumReset = 8'd4;

	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [15:0] remaining;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RUN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch request fields, restart the scan
		logic scan_step; // examine one slot
		logic decide;    // arrive or choose work
		logic run;       // run one tick
		logic emit;      // drive result strobe
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic scan_last;
	} stat_t;
endpackage

>>> design/prtq_ctrl.sv
// Controller state machine for the two-queue scheduler
module prtq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output prtq_pkg::ctrl_t ctrl,
	input  prtq_pkg::stat_t stat
);
	prtq_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= prtq_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prtq_pkg::ST_IDLE:   if (start) state_d = prtq_pkg::ST_SCAN;
			prtq_pkg::ST_SCAN:   if (stat.scan_last) state_d = prtq_pkg::ST_DECIDE;
			prtq_pkg::ST_DECIDE: state_d = stat.is_tick ? prtq_pkg::ST_RUN : prtq_pkg::ST_DONE;
			prtq_pkg::ST_RUN:    state_d = prtq_pkg::ST_DONE;
			prtq_pkg::ST_DONE:   state_d = prtq_pkg::ST_IDLE;
			default:             state_d = prtq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl = '0;
		busy = (state_q != prtq_pkg::ST_IDLE);
		unique case (state_q)
			prtq_pkg::ST_IDLE:   ctrl.load = start;
			prtq_pkg::ST_SCAN:   ctrl.scan_step = 1'b1;
			prtq_pkg::ST_DECIDE: ctrl.decide = 1'b1;
			prtq_pkg::ST_RUN:    ctrl.run = 1'b1;
			prtq_pkg::ST_DONE:   ctrl.emit = 1'b1;
			default: ;
		endcase
	end

	`include "priority_rr_two_queue_scheduler_macros.svh"
	`PRTQ_ASSERT(a_busy_idle, busy == (state_q != prtq_pkg::ST_IDLE), "busy mismatch")
	`PRTQ_ASSERT_NEXT(a_start_scan, start && !busy, state_q == prtq_pkg::ST_SCAN, "no scan")
	`PRTQ_ASSERT_NEXT(a_run_done, state_q == prtq_pkg::ST_RUN, ctrl.emit, "no emit")
endmodule

>>> design/prtq_datapath.sv
// Datapath: priority store, round-robin FIFO and running job
module prtq_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  prtq_pkg::ctrl_t ctrl,
	output prtq_pkg::stat_t stat,
	input  logic            command,
	input  logic [7:0]      job_id,
	input  logic [7:0]      job_priority,
	input  logic [15:0]     job_burst,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	output logic            done,
	output logic            running_valid,
	output logic [7:0]      running_id,
	output logic            job_done,
	output logic            arrival_dropped
);
	localparam int N = prtq_pkg::MaxJobs;
	localparam int IW = prtq_pkg::IdxW;
	localparam int CW = prtq_pkg::CntW;

	prtq_pkg::job_t store_q [N];
	logic [N-1:0] pvalid_q;
	prtq_pkg::job_t fifo_q [N];
	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] rcount_q, pused_q;
	prtq_pkg::job_t cur_q;
	logic cur_valid_q, cur_prio_q;
	logic [7:0] slice_q, quantum_q;
	logic cmd_q;
	prtq_pkg::job_t in_q;
	logic [IW-1:0] scan_q, best_q, free_q;
	logic best_ok_q, free_ok_q;
	logic rv_q, jd_q, drop_q;
	logic [7:0] rid_q;

	logic [7:0] slen;
	assign slen = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
	assign stat.is_tick = cmd_q;
	assign stat.scan_last = (scan_q == IW'(N - 1));

	// quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) quantum_q <= prtq_pkg::QuantumReset;
		else if (cfg_we) quantum_q <= cfg_wdata;
	end

	// request latch and sequential scan for best and free slot
	prtq_pkg::job_t sj, bj;
	logic better;
	assign sj = store_q[scan_q];
	assign bj = store_q[best_q];
	assign better = !best_ok_q || (sj.prio < bj.prio) || (sj.prio == bj.prio && sj.id < bj.id);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= 1'b0; scan_q <= '0; best_q <= '0; free_q <= '0;
			best_ok_q <= 1'b0; free_ok_q <= 1'b0;
		end else if (ctrl.load) begin
			cmd_q <= command;
			scan_q <= '0; best_ok_q <= 1'b0; free_ok_q <= 1'b0;
		end else if (ctrl.scan_step) begin
			if (pvalid_q[scan_q] && better) begin
				best_q <= scan_q; best_ok_q <= 1'b1;
			end
			if (!pvalid_q[scan_q] && !free_ok_q) begin
				free_q <= scan_q; free_ok_q <= 1'b1;
			end
			if (!stat.scan_last) scan_q <= scan_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			in_q.id <= job_id;
			in_q.prio <= job_priority;
			in_q.remaining <= (job_burst == 16'd0) ? 16'd1 : job_burst;
		end
	end

	// held count for admission
	logic [CW:0] held;
	assign held = {1'b0, pused_q} + {1'b0, rcount_q} + (CW+1)'(cur_valid_q);

	// decide and run
	logic push, pop, take, ins;
	prtq_pkg::job_t push_j;
	prtq_pkg::job_t fhead;
	assign fhead = fifo_q[head_q];
	always_comb begin
		push = 1'b0; pop = 1'b0; take = 1'b0; ins = 1'b0; push_j = cur_q;
		// a job whose slice runs out is queued with this tick already spent
		if (ctrl.run) push_j.remaining = cur_q.remaining - 16'd1;
		if (ctrl.decide && !cmd_q) ins = (held < (CW+1)'(N)) && free_ok_q;
		if (ctrl.decide && cmd_q) begin
			if (!cur_valid_q) begin
				if (best_ok_q) take = 1'b1;
				else if (rcount_q != '0) pop = 1'b1;
			end else if (best_ok_q && (!cur_prio_q || bj.prio < cur_q.prio)) begin
				take = 1'b1; push = 1'b1;
			end
		end
		if (ctrl.run && cur_valid_q && cur_q.remaining != 16'd1 && slice_q == 8'd1)
			push = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ins) store_q[free_q] <= in_q;
		if (push) fifo_q[tail_q] <= push_j;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0; pused_q <= '0; head_q <= '0; tail_q <= '0; rcount_q <= '0;
			cur_q <= '0; cur_valid_q <= 1'b0; cur_prio_q <= 1'b0; slice_q <= 8'd4;
			rv_q <= 1'b0; rid_q <= '0; jd_q <= 1'b0; drop_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				rv_q <= 1'b0; rid_q <= '0; jd_q <= 1'b0; drop_q <= 1'b0;
			end
			if (ctrl.decide && !cmd_q) drop_q <= !ins;
			if (ins) begin
				pvalid_q[free_q] <= 1'b1; pused_q <= pused_q + 1'b1;
			end
			if (push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (push && !pop) rcount_q <= rcount_q + 1'b1;
			else if (pop && !push) rcount_q <= rcount_q - 1'b1;
			if (pop) begin
				head_q <= head_q + 1'b1;
				cur_q <= fhead; cur_valid_q <= 1'b1; cur_prio_q <= 1'b0; slice_q <= slen;
			end
			if (take) begin
				pvalid_q[best_q] <= 1'b0; pused_q <= pused_q - 1'b1;
				cur_q <= bj; cur_valid_q <= 1'b1; cur_prio_q <= 1'b1; slice_q <= slen;
			end
			if (ctrl.run && cur_valid_q) begin
				rv_q <= 1'b1; rid_q <= cur_q.id;
				cur_q.remaining <= cur_q.remaining - 1'b1;
				if (cur_q.remaining == 16'd1) begin
					jd_q <= 1'b1; cur_valid_q <= 1'b0; cur_prio_q <= 1'b0; slice_q <= slen;
				end else begin
					slice_q <= slice_q - 1'b1;
					if (slice_q == 8'd1) begin
						cur_valid_q <= 1'b0; cur_prio_q <= 1'b0;
					end
				end
			end
		end
	end

	assign done = ctrl.emit;
	assign running_valid = rv_q;
	assign running_id = rid_q;
	assign job_done = jd_q;
	assign arrival_dropped = drop_q;

	`include "priority_rr_two_queue_scheduler_macros.svh"
	`PRTQ_ASSERT(a_held_cap, held <= (CW+1)'(N), "too many jobs held")
	`PRTQ_ASSERT(a_pused, pused_q == CW'($countones(pvalid_q)), "store count mismatch")
	`PRTQ_ASSERT(a_take_pop, !(take && pop), "take and pop together")
endmodule

>>> design/priority_rr_two_queue_scheduler.sv
// Sequence: a tick accepted in idle steps through scan, decide, run and done, and the result
// strobe comes in done; an arrival skips the run step.
// Busy is high while a request is being processed; a new request is taken only in idle.
// The time each request takes is set by the one-slot-per-cycle scan of the priority store.
// Results are strobed for one cycle; the receiver cannot stall.
// Asynchronous active-low reset empties both queues, idles the CPU, quantum 4.
module priority_rr_two_queue_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [7:0]  job_id,
	input  logic [7:0]  job_priority,
	input  logic [15:0] job_burst,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        done,
	output logic        running_valid,
	output logic [7:0]  running_id,
	output logic        job_done,
	output logic        arrival_dropped
);
	prtq_pkg::ctrl_t ctrl;
	prtq_pkg::stat_t stat;

	prtq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ctrl(ctrl), .stat(stat)
	);

	prtq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat),
		.command(command), .job_id(job_id), .job_priority(job_priority),
		.job_burst(job_burst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .running_valid(running_valid), .running_id(running_id),
		.job_done(job_done), .arrival_dropped(arrival_dropped)
	);
endmodule

>>> tb/priority_rr_two_queue_scheduler_tb.sv
// Self-checking testbench for the two-queue priority/round-robin scheduler
module priority_rr_two_queue_scheduler_tb;
	localparam logic CmdArrive = 1'b0;
	localparam logic CmdTick = 1'b1;

	typedef struct {
		logic        command;
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [15:0] burst;
	} request_t;

	typedef struct {
		logic       running_valid;
		logic [7:0] running_id;
		logic       job_done;
		logic       arrival_dropped;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        command = 1'b0;
	logic [7:0]  job_id = '0;
	logic [7:0]  job_priority = '0;
	logic [15:0] job_burst = '0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        done;
	logic        running_valid;
	logic [7:0]  running_id;
	logic        job_done;
	logic        arrival_dropped;

	priority_rr_two_queue_scheduler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .job_id(job_id), .job_priority(job_priority),
		.job_burst(job_burst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .running_valid(running_valid), .running_id(running_id),
		.job_done(job_done), .arrival_dropped(arrival_dropped)
	);

	always #5 clk = ~clk;

	// scheduler shadow state
	logic [7:0]       sh_quantum;
	prtq_pkg::job_t   sh_store [prtq_pkg::MaxJobs];
	logic             sh_stored [prtq_pkg::MaxJobs];
	prtq_pkg::job_t   sh_fifo [$];
	prtq_pkg::job_t   sh_cur;
	logic             sh_busy;
	logic             sh_from_prio;
	logic [7:0]       sh_slice;

	request_t pending_requests [$];
	outcome_t expected_outcomes [$];
	int       n_fail = 0;
	int       n_outcomes = 0;
	int       n_done_jobs = 0;
	int       n_drops = 0;
	bit       feeding = 1'b0;

	function automatic logic [7:0] slice_len();
		return (sh_quantum == 8'd0) ? 8'd1 : sh_quantum;
	endfunction

	function automatic void shadow_reset();
		sh_quantum = prtq_pkg::QuantumReset;
		for (int i = 0; i < prtq_pkg::MaxJobs; i++) sh_stored[i] = 1'b0;
		sh_fifo.delete();
		sh_cur = '0;
		sh_busy = 1'b0;
		sh_from_prio = 1'b0;
		sh_slice = prtq_pkg::QuantumReset;
	endfunction

	function automatic void grab_stored(int idx);
		sh_cur = sh_store[idx];
		sh_stored[idx] = 1'b0;
		sh_busy = 1'b1;
		sh_from_prio = 1'b1;
		sh_slice = slice_len();
	endfunction

	// predict the outcome of one accepted request
	function automatic outcome_t schedule_request(request_t r);
		outcome_t o;
		int held;
		int best;
		o = '{1'b0, 8'd0, 1'b0, 1'b0};
		if (r.command == CmdArrive) begin
			held = sh_fifo.size() + (sh_busy ? 1 : 0);
			foreach (sh_stored[i]) if (sh_stored[i]) held++;
			if (held >= prtq_pkg::MaxJobs) begin
				o.arrival_dropped = 1'b1;
				return o;
			end
			for (int i = 0; i < prtq_pkg::MaxJobs; i++) begin
				if (!sh_stored[i]) begin
					sh_store[i] = '{r.id, r.prio, (r.burst == 16'd0) ? 16'd1 : r.burst};
					sh_stored[i] = 1'b1;
					break;
				end
			end
			return o;
		end
		best = -1;
		for (int i = 0; i < prtq_pkg::MaxJobs; i++) begin
			if (!sh_stored[i]) continue;
			if (best < 0 || sh_store[i].prio < sh_store[best].prio ||
					(sh_store[i].prio == sh_store[best].prio &&
					sh_store[i].id < sh_store[best].id))
				best = i;
		end
		if (!sh_busy) begin
			if (best >= 0) grab_stored(best);
			else if (sh_fifo.size() > 0) begin
				sh_cur = sh_fifo.pop_front();
				sh_busy = 1'b1;
				sh_from_prio = 1'b0;
				sh_slice = slice_len();
			end
		end else if (best >= 0) begin
			if (!sh_from_prio || sh_store[best].prio < sh_cur.prio) begin
				sh_fifo.push_back(sh_cur);
				grab_stored(best);
			end
		end
		if (sh_busy) begin
			o.running_valid = 1'b1;
			o.running_id = sh_cur.id;
			sh_cur.remaining = sh_cur.remaining - 16'd1;
			sh_slice = sh_slice - 8'd1;
			if (sh_cur.remaining == 16'd0) begin
				o.job_done = 1'b1;
				sh_busy = 1'b0;
				sh_from_prio = 1'b0;
				sh_slice = slice_len();
			end else if (sh_slice == 8'd0) begin
				sh_fifo.push_back(sh_cur);
				sh_busy = 1'b0;
				sh_from_prio = 1'b0;
			end
		end
		return o;
	endfunction

	// driver: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_outcomes.push_back(schedule_request(pending_requests.pop_front()));
		end
		if (start && busy) begin
			// hold the current request
		end else if (feeding && pending_requests.size() > 0 && gap_left == 0) begin
			start <= 1'b1;
			command <= pending_requests[0].command;
			job_id <= pending_requests[0].id;
			job_priority <= pending_requests[0].prio;
			job_burst <= pending_requests[0].burst;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			end else burst_left--;
		end else begin
			start <= 1'b0;
			if (gap_left > 0) gap_left--;
		end
	end

	// monitor: compare each strobed result
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$error("result strobe with no request outstanding");
				n_fail++;
			end else begin
				e = expected_outcomes.pop_front();
				n_outcomes++;
				if (job_done) n_done_jobs++;
				if (arrival_dropped) n_drops++;
				if (running_valid !== e.running_valid) begin
					$error("running_valid exp %0d got %0d", e.running_valid, running_valid);
					n_fail++;
				end
				if (running_id !== e.running_id) begin
					$error("running_id exp %0d got %0d", e.running_id, running_id);
					n_fail++;
				end
				if (job_done !== e.job_done) begin
					$error("job_done exp %0d got %0d", e.job_done, job_done);
					n_fail++;
				end
				if (arrival_dropped !== e.arrival_dropped) begin
					$error("arrival_dropped exp %0d got %0d", e.arrival_dropped,
						arrival_dropped);
					n_fail++;
				end
			end
		end
	end

	function automatic request_t mk(logic c, logic [7:0] i, logic [7:0] p,
			logic [15:0] b);
		request_t r;
		r = '{c, i, p, b};
		return r;
	endfunction

	function automatic request_t rand_request(int tick_pct);
		request_t r;
		r.command = ($urandom_range(0, 99) < tick_pct) ? CmdTick : CmdArrive;
		r.id = 8'($urandom);
		r.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		case ($urandom_range(0, 9))
			0: r.burst = 16'($urandom);
			1: r.burst = 16'd0;
			default: r.burst = 16'($urandom_range(1, 12));
		endcase
		return r;
	endfunction

	// run queued requests to completion, then let the block settle
	task automatic drain();
		feeding = 1'b1;
		while (pending_requests.size() > 0 || start) @(posedge clk);
		feeding = 1'b0;
		while (expected_outcomes.size() > 0) @(posedge clk);
		repeat (prtq_pkg::MaxJobs + 8) @(posedge clk);
	endtask

	task automatic set_quantum(logic [7:0] q);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_quantum = q;
	endtask

	initial begin
		logic [7:0] quanta [6];
		quanta = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd7};
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes, ties, preemption, zero burst, overflow
		pending_requests.push_back(mk(CmdTick, 8'hff, 8'hff, 16'hffff));
		pending_requests.push_back(mk(CmdArrive, 8'd5, 8'd200, 16'd0));
		pending_requests.push_back(mk(CmdArrive, 8'd255, 8'd255, 16'hffff));
		pending_requests.push_back(mk(CmdArrive, 8'd3, 8'd10, 16'd6));
		pending_requests.push_back(mk(CmdArrive, 8'd3, 8'd10, 16'd2));
		pending_requests.push_back(mk(CmdArrive, 8'd1, 8'd10, 16'd3));
		pending_requests.push_back(mk(CmdTick, 8'd0, 8'd0, 16'd0));
		pending_requests.push_back(mk(CmdArrive, 8'd0, 8'd0, 16'd1));
		pending_requests.push_back(mk(CmdTick, 8'd0, 8'd0, 16'd0));
		for (int i = 0; i < 12; i++)
			pending_requests.push_back(mk(CmdArrive, 8'(i + 20), 8'd50, 16'd1));
		for (int i = 0; i < 4; i++)
			pending_requests.push_back(mk(CmdTick, 8'd0, 8'd0, 16'd0));
		drain();

		// random phases over several quantum settings
		for (int ph = 0; ph < 6; ph++) begin
			set_quantum(quanta[ph]);
			for (int i = 0; i < 140; i++)
				pending_requests.push_back(rand_request((ph % 2) ? 70 : 50));
			drain();
		end

		$display("Checked %0d results: %0d jobs completed, %0d arrivals dropped,",
			n_outcomes, n_done_jobs, n_drops);
		$display("quantum settings 4, 1, 255, 0, 2, 3 and 7 exercised.");
		if (n_fail == 0 && expected_outcomes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/prtq_pkg.sv
design/prtq_ctrl.sv
design/prtq_datapath.sv
design/priority_rr_two_queue_scheduler.sv
tb/priority_rr_two_queue_scheduler_tb.sv
